>>> rtl/pli_pkg.sv
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;

    // grid depth; the index and count port widths are sized for it
    localparam int MAX_POINTS = 1024;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic latch_query;
        logic rd_lo;
        logic rd_hi;
        logic rd_start;
        logic load_start;
        logic step;
        logic load_end;
        logic setup_math;
        logic mul_lo;
        logic mul_hi;
        logic div_start;
        logic out_zero;
        logic out_oerr;
        logic out_val;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_grid;
        logic below;
        logic advance;
        logic div_done;
    } t_dp_stat;

endpackage

>>> rtl/pli_div.sv
// Restoring divider, one quotient bit per cycle.
// The caller guarantees dividend[64:33] < divisor, so the quotient fits 33 bits.
module pli_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [64:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [32:0] o_quotient
);
    import pli_pkg::*;

    localparam int STEPS = 33;

    logic [31:0] r_rem;
    logic [32:0] r_sh;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;

    logic [32:0] t_val;
    logic [32:0] t_sub;
    logic        ge;

    assign t_val = {r_rem, r_sh[32]};
    assign t_sub = t_val - {1'b0, r_dvs};
    assign ge    = (t_val >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[64:33];
            r_sh  <= i_dividend[32:0];
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= ge ? t_sub[31:0] : t_val[31:0];
            r_sh  <= {r_sh[31:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;

endmodule

>>> rtl/pli_dp.sv
// Grid memory, segment pointer, operand registers and result arithmetic.
module pli_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pli_pkg::t_dp_cmd              i_cmd,
    output pli_pkg::t_dp_stat             o_stat,
    input  logic                          i_wr,
    input  logic [pli_pkg::IDX_W-1:0]     i_point_index,
    input  logic signed [pli_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] i_query_x,
    input  logic                          i_first_query,
    input  logic                          i_cfg_wr_en,
    input  logic [pli_pkg::CNT_W-1:0]     i_cfg_wr_data,
    output logic signed [pli_pkg::DATA_W-1:0] o_value,
    output logic                          o_inside_res,
    output logic                          o_order_error
);
    import pli_pkg::*;

    localparam int SW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    logic [2*DATA_W-1:0] mem [MAX_POINTS];

    logic [CNT_W-1:0] r_grid_count;
    logic [SW-1:0]    r_seg;
    logic [SW-1:0]    nm1;
    logic [SW-1:0]    seg_base;
    logic [SW-1:0]    rd_addr;
    logic [2*DATA_W-1:0] r_rd;
    logic signed [DATA_W-1:0] rd_x;

    logic signed [DATA_W-1:0] r_q, r_x0, r_y0, r_x1, r_y1;
    logic r_ge_lo, r_le_hi;

    logic signed [DATA_W:0] dx, dq, dy;
    logic [31:0] dq_cl;
    logic [32:0] absdy;
    logic [31:0] r_dx, r_dq;
    logic [32:0] r_absdy;
    logic        r_neg, r_degen;
    logic [47:0] r_plo;
    logic [48:0] r_phi;
    logic [64:0] prod;
    logic        div_done;
    logic [32:0] quot;
    logic signed [34:0] sum;

    assign rd_x = r_rd[2*DATA_W-1:DATA_W];

    // effective point count minus one
    always_comb begin
        if ({21'b0, r_grid_count} > 32'(MAX_POINTS)) nm1 = SW'(MAX_POINTS - 1);
        else if (r_grid_count < 11'd2)             nm1 = SW'(1);
        else                                        nm1 = SW'(r_grid_count - 11'd1);
    end

    always_comb begin
        seg_base = i_first_query ? SW'(1) : r_seg;
        rd_addr  = '0;
        if (i_cmd.rd_lo)         rd_addr = '0;
        else if (i_cmd.rd_hi)    rd_addr = nm1;
        else if (i_cmd.rd_start) rd_addr = r_seg - SW'(1);
        else if (i_cmd.load_start) rd_addr = r_seg;
        else if (i_cmd.step)     rd_addr = r_seg + SW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && ({22'b0, i_point_index} < 32'(MAX_POINTS)))
            mem[SW'(i_point_index)] <= {i_point_x, i_point_y};
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_count <= CNT_W'(2);
            r_seg        <= SW'(1);
        end else begin
            if (i_cfg_wr_en) r_grid_count <= i_cfg_wr_data;
            if (i_cmd.latch_query) begin
                if (seg_base == '0)   r_seg <= SW'(1);
                else if (seg_base > nm1) r_seg <= nm1;
                else                  r_seg <= seg_base;
            end else if (i_cmd.step) begin
                r_seg <= r_seg + SW'(1);
            end
        end
    end

    // arithmetic on the found segment
    always_comb begin
        dx = {r_x1[31], r_x1} - {r_x0[31], r_x0};
        dq = {r_q[31], r_q}   - {r_x0[31], r_x0};
        dy = {r_y1[31], r_y1} - {r_y0[31], r_y0};
        if (dq < 0)       dq_cl = '0;
        else if (dq > dx) dq_cl = dx[31:0];
        else              dq_cl = dq[31:0];
        absdy = dy[32] ? 33'(-dy) : 33'(dy);
    end

    assign prod = {r_phi, 16'b0} + {17'b0, r_plo};

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (prod),
        .i_divisor  (r_dx),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign sum = r_neg ? (35'(r_y0) - 35'(quot)) : (35'(r_y0) + 35'(quot));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_query) r_q <= i_query_x;
        if (i_cmd.rd_hi)       r_ge_lo <= (r_q >= rd_x);
        if (i_cmd.rd_start)    r_le_hi <= (r_q <= rd_x);
        if (i_cmd.load_start || i_cmd.step) begin
            r_x0 <= rd_x;
            r_y0 <= r_rd[DATA_W-1:0];
        end
        if (i_cmd.load_end) begin
            r_x1 <= rd_x;
            r_y1 <= r_rd[DATA_W-1:0];
        end
        if (i_cmd.setup_math) begin
            r_degen <= (dx <= 0);
            r_dx    <= dx[31:0];
            r_dq    <= dq_cl;
            r_absdy <= absdy;
            r_neg   <= dy[32];
        end
        if (i_cmd.mul_lo) r_plo <= r_absdy[15:0] * r_dq;
        if (i_cmd.mul_hi) r_phi <= r_absdy[32:16] * r_dq;
        if (i_cmd.out_zero || i_cmd.out_oerr) begin
            o_value       <= '0;
            o_inside_res  <= i_cmd.out_oerr;
            o_order_error <= i_cmd.out_oerr;
        end else if (i_cmd.out_val) begin
            o_inside_res  <= 1'b1;
            o_order_error <= 1'b0;
            if (r_degen)                   o_value <= r_y0;
            else if (sum > 35'sd2147483647)  o_value <= 32'h7FFF_FFFF;
            else if (sum < -35'sd2147483648) o_value <= 32'h8000_0000;
            else                           o_value <= sum[31:0];
        end
    end

    assign o_stat.in_grid  = r_ge_lo && r_le_hi;
    assign o_stat.below    = (r_q < rd_x);
    assign o_stat.advance  = (r_seg < nm1) && (rd_x < r_q);
    assign o_stat.div_done = div_done;

endmodule

>>> rtl/pli_ctrl.sv
// Query sequencer: grid bounds, segment walk, multiply, divide, result.
module pli_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_query,
    input  pli_pkg::t_dp_stat i_stat,
    output pli_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import pli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LO, S_HI, S_ST, S_CHK, S_WALK,
        S_MATH, S_MLO, S_MHI, S_SUM, S_DIV
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    o_cmd.latch_query = 1'b1;
                    n_state = S_LO;
                end
            end
            S_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state = S_HI;
            end
            S_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state = S_ST;
            end
            S_ST: begin
                o_cmd.rd_start = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.load_start = 1'b1;
                if (!i_stat.in_grid) begin
                    o_cmd.out_zero = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.below) begin
                    o_cmd.out_oerr = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.advance) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.load_end = 1'b1;
                    n_state = S_MATH;
                end
            end
            S_MATH: begin
                o_cmd.setup_math = 1'b1;
                n_state = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.out_val = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

>>> rtl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator over a grid of up to MAX_POINTS (x, y) points,
// all signed Q16.16. An item is taken when start is high and busy is low.
// A write item (command 0) stores one point in the same cycle and leaves busy
// low, so writes can stream one per clock. A query item (command 1) returns
// exactly one result, shown for a single cycle with o_valid high; the receiver
// cannot stall, so capture it then. A query takes three grid reads for the bounds
// and segment start, a walk of one grid entry per cycle over the single memory
// read port, a multiply split into low and high halves, and a bit-serial
// divide. A query outside the grid or below the segment start is answered
// after the bounds check. Outside the grid the result is 0 with inside clear;
// a query below the current segment start flags o_order_error. first_query
// restarts the pointer at the first segment. grid_count is written through
// i_cfg_wr_en/i_cfg_wr_data; the user must write it only while idle, since the
// block itself does not enforce this.
module piecewise_linear_interpolator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [pli_pkg::IDX_W-1:0]         i_point_index,
    input  logic signed [pli_pkg::DATA_W-1:0] i_point_x,
    input  logic signed [pli_pkg::DATA_W-1:0] i_point_y,
    input  logic signed [pli_pkg::DATA_W-1:0] i_query_x,
    input  logic                              i_first_query,
    input  logic                              i_cfg_wr_en,
    input  logic [pli_pkg::CNT_W-1:0]         i_cfg_wr_data,
    output logic                              o_valid,
    output logic signed [pli_pkg::DATA_W-1:0] o_value,
    output logic                              o_inside_res,
    output logic                              o_order_error
);
    import pli_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     accept;

    assign accept = start && !busy;

    pli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (accept && (i_command == CMD_QUERY)),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    pli_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_wr          (accept && (i_command == CMD_WRITE)),
        .i_point_index (i_point_index),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_query_x     (i_query_x),
        .i_first_query (i_first_query),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_value       (o_value),
        .o_inside_res  (o_inside_res),
        .o_order_error (o_order_error)
    );

endmodule
